/* rtl/lpc_pkg.sv */
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared constants, register codes and types of the levitation PID loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

  // Sample groups.
  localparam int NUM_SAMPLES         = 5;
  localparam int SAMPLES_PER_AVERAGE = 5;
  localparam int SAMPLE_W            = 8;
  localparam int SUM_W               = 11;

  // Averaging by reciprocal: floor(sum / N) == (sum * AVG_RECIP) >> AVG_SHIFT
  // for every sum below 2**SUM_W, with N = SAMPLES_PER_AVERAGE.
  localparam int AVG_SHIFT   = 14;
  localparam int AVG_RECIP_W = 15;
  localparam int AVG_RECIP_I = ((2 ** AVG_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(AVG_RECIP_I);

  // Integral scaling: magnitude of a 32-bit value divided by INTEGRAL_DIVISOR
  // through a rounded-up reciprocal that is exact for all 32-bit magnitudes.
  localparam int INTEGRAL_DIVISOR = 600;
  localparam int INTEG_W          = 32;
  localparam int DIV_SHIFT        = INTEG_W + $clog2(INTEGRAL_DIVISOR);
  localparam int DIV_RECIP_W      = 33;
  localparam logic [63:0] DIV_RECIP_WIDE =
    ((64'd1 << DIV_SHIFT) + 64'(INTEGRAL_DIVISOR) - 64'd1) / 64'(INTEGRAL_DIVISOR);
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_WIDE[DIV_RECIP_W-1:0];
  localparam int HALF_W = INTEG_W / 2;
  localparam int PP_W   = HALF_W + DIV_RECIP_W;
  localparam int PROD_W = INTEG_W + DIV_RECIP_W;
  localparam int QUOT_W = INTEG_W + 1;

  // Register file.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_SETPOINT_LIMIT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_BIAS     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OUT_LIMIT      = 3'd4;

  localparam logic [7:0] RST_SETPOINT_LIMIT = 8'd45;
  localparam logic [7:0] RST_PROP_GAIN      = 8'd2;
  localparam logic [9:0] RST_DERIV_GAIN     = 10'd100;
  localparam logic [8:0] RST_DRIVE_BIAS     = 9'd200;
  localparam logic [7:0] RST_OUT_LIMIT      = 8'd255;

  typedef struct packed {
    logic [7:0]        setpoint_limit;
    logic [7:0]        prop_gain;
    logic [9:0]        deriv_gain;
    logic signed [8:0] drive_bias;
    logic [7:0]        out_limit;
  } lpc_cfg_t;

  // Load enables of the two divider stages.
  typedef struct packed {
    logic ld_prod;
    logic ld_quot;
  } lpc_div_ctl_t;

endpackage

`default_nettype wire

/* rtl/lpc_regs.sv */
// ----------------------------------------------------------------------------
// lpc_regs
// APB register file holding the loop gains, limits and drive bias.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lpc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lpc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lpc_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready,
  output lpc_pkg::lpc_cfg_t                  cfg
);
  import lpc_pkg::*;

  lpc_cfg_t             cfg_r;
  lpc_cfg_t             cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_SETPOINT_LIMIT: cfg_nxt.setpoint_limit = pwdata[7:0];
        REG_PROP_GAIN:      cfg_nxt.prop_gain      = pwdata[7:0];
        REG_DERIV_GAIN:     cfg_nxt.deriv_gain     = pwdata[9:0];
        REG_DRIVE_BIAS:     cfg_nxt.drive_bias     = $signed(pwdata[8:0]);
        REG_OUT_LIMIT:      cfg_nxt.out_limit      = pwdata[7:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_limit <= RST_SETPOINT_LIMIT;
      cfg_r.prop_gain      <= RST_PROP_GAIN;
      cfg_r.deriv_gain     <= RST_DERIV_GAIN;
      cfg_r.drive_bias     <= $signed(RST_DRIVE_BIAS);
      cfg_r.out_limit      <= RST_OUT_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SETPOINT_LIMIT: prdata = {24'd0, cfg_r.setpoint_limit};
      REG_PROP_GAIN:      prdata = {24'd0, cfg_r.prop_gain};
      REG_DERIV_GAIN:     prdata = {22'd0, cfg_r.deriv_gain};
      REG_DRIVE_BIAS:     prdata = {23'd0, cfg_r.drive_bias};
      REG_OUT_LIMIT:      prdata = {24'd0, cfg_r.out_limit};
      default:            prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/lpc_idiv.sv */
// ----------------------------------------------------------------------------
// lpc_idiv
// Two-stage signed division of the integral by a constant, toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpc_idiv (
  input  wire logic                                clk,
  input  wire lpc_pkg::lpc_div_ctl_t               ctl,
  input  wire logic signed [lpc_pkg::INTEG_W-1:0]  num,
  output logic signed      [lpc_pkg::QUOT_W-1:0]   quot
);
  import lpc_pkg::*;

  logic [INTEG_W-1:0] mag;
  logic [PP_W-1:0]    pp_hi_r;
  logic [PP_W-1:0]    pp_lo_r;
  logic               neg_a_r;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  prod_shift;
  logic [INTEG_W-1:0] qmag_r;
  logic               neg_b_r;

  // The most negative value maps to 2**31, which still fits unsigned.
  assign mag = num[INTEG_W-1] ? INTEG_W'(-num) : num;

  // First stage: two half-width partial products against the reciprocal.
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      pp_hi_r <= mag[INTEG_W-1:HALF_W] * DIV_RECIP;
      pp_lo_r <= mag[HALF_W-1:0] * DIV_RECIP;
      neg_a_r <= num[INTEG_W-1];
    end
  end

  assign prod       = {pp_hi_r, {HALF_W{1'b0}}} + {{(PROD_W-PP_W){1'b0}}, pp_lo_r};
  assign prod_shift = prod >> DIV_SHIFT;

  always_ff @(posedge clk) begin
    if (ctl.ld_quot) begin
      qmag_r  <= prod_shift[INTEG_W-1:0];
      neg_b_r <= neg_a_r;
    end
  end

  assign quot = neg_b_r ? -$signed({1'b0, qmag_r}) : $signed({1'b0, qmag_r});

endmodule

`default_nettype wire

/* rtl/levitation_pid_controller.sv */
// ----------------------------------------------------------------------------
// levitation_pid_controller
// PID loop for a magnetic levitation coil with a saturated, signed drive.
// Throughput: one request per cycle while the output is not stalled; the seven
// pipeline stages each hold one request and close up bubbles, so requests keep
// entering while a result waits, until every stage is full.
// The integral and last-field state close their feedback loop in one stage.
// Reset (rst_n, synchronous): empties the pipeline, clears the state and loads
// the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module levitation_pid_controller (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Sample request channel.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_set_s0,
  input  wire logic [7:0]                     in_set_s1,
  input  wire logic [7:0]                     in_set_s2,
  input  wire logic [7:0]                     in_set_s3,
  input  wire logic [7:0]                     in_set_s4,
  input  wire logic [7:0]                     in_fld_s0,
  input  wire logic [7:0]                     in_fld_s1,
  input  wire logic [7:0]                     in_fld_s2,
  input  wire logic [7:0]                     in_fld_s3,
  input  wire logic [7:0]                     in_fld_s4,
  // Drive request channel.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_drive_magnitude,
  output logic                                out_drive_reverse,
  // Register port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lpc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lpc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lpc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import lpc_pkg::*;

  localparam int CTRL_W = 35;

  lpc_cfg_t     cfg;
  lpc_div_ctl_t div_ctl;

  // Per-stage valid flags and advance enables. A stage loads when it is
  // empty or when the stage after it loads, so bubbles are squeezed out.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, out_vld_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  logic [SAMPLE_W-1:0] set_arr [NUM_SAMPLES];
  logic [SAMPLE_W-1:0] fld_arr [NUM_SAMPLES];

  // Stage 1: sample sums.
  logic [SUM_W-1:0] set_sum, fld_sum;
  logic [SUM_W-1:0] set_sum_r, fld_sum_r;

  // Stage 2: averages and setpoint clamp.
  logic [SUM_W+AVG_RECIP_W-1:0] set_prod, fld_prod;
  logic [7:0] set_avg, fld_avg, ref_val;
  logic [7:0] ref_r, fld_r;

  // Stage 3: error, derivative and the integral state.
  logic signed [8:0]         err, diff;
  logic signed [INTEG_W:0]   integ_wide;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [INTEG_W-1:0] integ_r;
  logic [7:0]                last_field_r;
  logic signed [8:0]         err_r, diff_r;
  logic signed [INTEG_W-1:0] integ_s3_r;

  // Stage 4 and 5: gain products, carried beside the divider.
  logic signed [17:0] p_term_r, p_term5_r;
  logic signed [19:0] d_term_r, d_term5_r;

  // Stage 6: drive sum.
  logic signed [QUOT_W-1:0] quot;
  logic signed [CTRL_W-1:0] ctrl_nxt, ctrl_r;

  // Output stage: saturation.
  logic signed [CTRL_W-1:0] lim, neg_lim, sat;
  logic [CTRL_W-1:0]        sat_mag;
  logic [7:0]               mag_r;
  logic                     rev_r;

  lpc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Flow control.
  assign en7 = !out_vld_r || !out_stall;
  assign en6 = !s6_vld_r || en7;
  assign en5 = !s5_vld_r || en6;
  assign en4 = !s4_vld_r || en5;
  assign en3 = !s3_vld_r || en4;
  assign en2 = !s2_vld_r || en3;
  assign en1 = !s1_vld_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en1) s1_vld_r  <= in_valid;
      if (en2) s2_vld_r  <= s1_vld_r;
      if (en3) s3_vld_r  <= s2_vld_r;
      if (en4) s4_vld_r  <= s3_vld_r;
      if (en5) s5_vld_r  <= s4_vld_r;
      if (en6) s6_vld_r  <= s5_vld_r;
      if (en7) out_vld_r <= s6_vld_r;
    end
  end

  // Stage 1: only the first SAMPLES_PER_AVERAGE samples of a group count.
  assign set_arr = '{in_set_s0, in_set_s1, in_set_s2, in_set_s3, in_set_s4};
  assign fld_arr = '{in_fld_s0, in_fld_s1, in_fld_s2, in_fld_s3, in_fld_s4};

  always_comb begin
    set_sum = '0;
    fld_sum = '0;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      if (i < SAMPLES_PER_AVERAGE) begin
        set_sum = set_sum + SUM_W'(set_arr[i]);
        fld_sum = fld_sum + SUM_W'(fld_arr[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      set_sum_r <= set_sum;
      fld_sum_r <= fld_sum;
    end
  end

  // Stage 2: the truncating average is a multiply by a rounded-up reciprocal.
  assign set_prod = set_sum_r * AVG_RECIP;
  assign fld_prod = fld_sum_r * AVG_RECIP;
  assign set_avg  = set_prod[AVG_SHIFT +: 8];
  assign fld_avg  = fld_prod[AVG_SHIFT +: 8];
  assign ref_val  = (set_avg >= cfg.setpoint_limit) ? cfg.setpoint_limit : set_avg;

  always_ff @(posedge clk) begin
    if (en2) begin
      ref_r <= ref_val;
      fld_r <= fld_avg;
    end
  end

  // Stage 3: the integral saturates at the 32-bit signed limits.
  assign err        = $signed({1'b0, ref_r}) - $signed({1'b0, fld_r});
  assign diff       = $signed({1'b0, last_field_r}) - $signed({1'b0, fld_r});
  assign integ_wide = {integ_r[INTEG_W-1], integ_r} + {{(INTEG_W-8){err[8]}}, err};

  always_comb begin
    if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
      integ_nxt = integ_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = integ_wide[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r      <= '0;
      last_field_r <= '0;
    end else if (en3 && s2_vld_r) begin
      integ_r      <= integ_nxt;
      last_field_r <= fld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      err_r      <= err;
      diff_r     <= diff;
      integ_s3_r <= integ_nxt;
    end
  end

  // Stages 4 and 5: the divider works while the gain products wait beside it.
  assign div_ctl.ld_prod = en4;
  assign div_ctl.ld_quot = en5;

  lpc_idiv u_idiv (
    .clk  (clk),
    .ctl  (div_ctl),
    .num  (integ_s3_r),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (en4) begin
      p_term_r <= err_r * $signed({1'b0, cfg.prop_gain});
      d_term_r <= diff_r * $signed({1'b0, cfg.deriv_gain});
    end
    if (en5) begin
      p_term5_r <= p_term_r;
      d_term5_r <= d_term_r;
    end
  end

  // Stage 6: integral share plus bias plus the two gain terms.
  assign ctrl_nxt = {{(CTRL_W-QUOT_W){quot[QUOT_W-1]}}, quot}
                  + {{(CTRL_W-9){cfg.drive_bias[8]}}, cfg.drive_bias}
                  + {{(CTRL_W-18){p_term5_r[17]}}, p_term5_r}
                  + {{(CTRL_W-20){d_term5_r[19]}}, d_term5_r};

  always_ff @(posedge clk) begin
    if (en6) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  // Output stage: clamp to plus or minus out_limit, then split into
  // magnitude and direction. A zero limit always gives a forward zero.
  assign lim     = $signed({{(CTRL_W-8){1'b0}}, cfg.out_limit});
  assign neg_lim = -lim;

  always_comb begin
    if (ctrl_r > lim) begin
      sat = lim;
    end else if (ctrl_r < neg_lim) begin
      sat = neg_lim;
    end else begin
      sat = ctrl_r;
    end
  end

  assign sat_mag = sat[CTRL_W-1] ? CTRL_W'(-sat) : sat;

  always_ff @(posedge clk) begin
    if (en7) begin
      mag_r <= sat_mag[7:0];
      rev_r <= sat[CTRL_W-1];
    end
  end

  assign out_valid           = out_vld_r;
  assign out_drive_magnitude = mag_r;
  assign out_drive_reverse   = rev_r;

  // The loop state moves only when a request passes into the third stage.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(en3 && s2_vld_r) |=> ($stable(integ_r) && $stable(last_field_r)))
    else $error("loop state changed without a request");

  // An empty first stage never pushes back on the sample channel.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> !in_stall)
    else $error("sample channel stalled with an empty first stage");

  // An accepted request always occupies the first stage next.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_vld_r)
    else $error("accepted request lost at the first stage");

  // A reverse drive always has a nonzero magnitude.
  a_reverse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_drive_reverse) |-> (out_drive_magnitude != 8'd0))
    else $error("reverse drive with zero magnitude");

endmodule

`default_nettype wire
